FILE: sv/ebga_pkg.sv
// Shared types, constants and register codes of the eye blink and gaze animator.
`default_nettype none

package ebga_pkg;

  // Default width of the time base and of all stored times.
  localparam int TIME_WIDTH_DEF = 32;

  // Field widths.
  localparam int NOW_W      = 32;
  localparam int GAP_W      = 16;
  localparam int DUR_W      = 16;
  localparam int LEVEL_W    = 9;
  localparam int HEIGHT_W   = 10;
  localparam int RADIUS_W   = 9;
  localparam int GAZE_W     = 5;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register reset values.
  localparam logic [DUR_W-1:0]    BLINK_DURATION_RST   = 16'd150;
  localparam logic [LEVEL_W-1:0]  CLOSED_LEVEL_RST     = 9'd13;
  localparam logic [DUR_W-1:0]    SACCADE_DURATION_RST = 16'd120;
  localparam logic [HEIGHT_W-1:0] EYE_FULL_HEIGHT_RST  = 10'd96;
  localparam logic [HEIGHT_W-1:0] EYE_WIDTH_RST        = 10'd78;
  localparam logic [RADIUS_W-1:0] CORNER_LIMIT_RST     = 9'd24;

  // Fixed-point constants.
  localparam logic [LEVEL_W-1:0]  Q8_ONE       = 9'd256;
  localparam logic [16:0]         Q16_ONE      = 17'h10000;
  localparam logic [17:0]         SMOOTH_THREE = 18'd196608;
  localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = 10'd4;

  // Divider step counts.
  localparam int                    DIV_STEPS_W    = 5;
  localparam logic [DIV_STEPS_W-1:0] TRI_STEPS      = 5'd8;
  localparam logic [DIV_STEPS_W-1:0] PROGRESS_STEPS = 5'd16;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_BLINK_DURATION   = 3'd0,
    REG_CLOSED_LEVEL     = 3'd1,
    REG_SACCADE_DURATION = 3'd2,
    REG_EYE_FULL_HEIGHT  = 3'd3,
    REG_EYE_WIDTH        = 3'd4,
    REG_CORNER_LIMIT     = 3'd5
  } ebga_reg_t;

  // Configuration register set.
  typedef struct packed {
    logic [DUR_W-1:0]    blink_duration;
    logic [LEVEL_W-1:0]  closed_level;
    logic [DUR_W-1:0]    saccade_duration;
    logic [HEIGHT_W-1:0] eye_full_height;
    logic [HEIGHT_W-1:0] eye_width;
    logic [RADIUS_W-1:0] corner_limit;
  } ebga_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic trigger;
    logic bdiv_start;
    logic open_en;
    logic height_en;
    logic pdiv_start;
    logic p2_en;
    logic smooth_en;
    logic gaze_en;
    logic out_load;
  } ebga_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
  } ebga_status_t;

endpackage

`default_nettype wire

FILE: sv/ebga_if.sv
// Valid/ready channel interfaces for frame ticks and animation results.
`default_nettype none

interface ebga_frame_if import ebga_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [NOW_W-1:0]        now_ms;
  logic [GAP_W-1:0]        blink_gap;
  logic signed [GAZE_W-1:0] target_x;
  logic signed [GAZE_W-1:0] target_y;
  logic [GAP_W-1:0]        saccade_gap;

  modport source (output valid, now_ms, blink_gap, target_x, target_y, saccade_gap,
                  input ready);
  modport sink (input valid, now_ms, blink_gap, target_x, target_y, saccade_gap,
                output ready);
endinterface

interface ebga_result_if import ebga_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [LEVEL_W-1:0]       eye_open;
  logic [HEIGHT_W-1:0]      eye_height;
  logic [RADIUS_W-1:0]      corner_radius;
  logic signed [GAZE_W-1:0] gaze_x;
  logic signed [GAZE_W-1:0] gaze_y;

  modport source (output valid, eye_open, eye_height, corner_radius, gaze_x, gaze_y,
                  input ready);
  modport sink (input valid, eye_open, eye_height, corner_radius, gaze_x, gaze_y,
                output ready);
endinterface

`default_nettype wire

FILE: sv/ebga_div.sv
// Restoring divider, one quotient bit per cycle, for fractions below one.
`default_nettype none

module ebga_div import ebga_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [DUR_W-1:0]       rem_init,
  input  wire logic [DUR_W-1:0]       divisor,
  input  wire logic [DIV_STEPS_W-1:0] steps,
  output logic                        busy,
  output logic [DUR_W-1:0]            quot
);

  logic [DIV_STEPS_W-1:0] cnt;
  logic [DUR_W-1:0]       rem;
  logic [DUR_W-1:0]       dvsr;
  logic [DUR_W:0]         rem_shift;
  logic [DUR_W:0]         rem_sub;
  logic                   fits;

  // One trial subtraction of the doubled remainder against the held divisor.
  always_comb begin
    rem_shift = {rem, 1'b0};
    rem_sub   = rem_shift - {1'b0, dvsr};
    fits      = rem_shift >= {1'b0, dvsr};
  end

  assign busy = cnt != '0;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - DIV_STEPS_W'(1);
    end
  end

  // Remainder and quotient shift; the divisor is held for the whole division.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      dvsr <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? rem_sub[DUR_W-1:0] : rem_shift[DUR_W-1:0];
      quot <= {quot[DUR_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

FILE: sv/ebga_dp.sv
// Datapath: animation state, openness and height math, smoothstep gaze easing.
`default_nettype none

module ebga_dp import ebga_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ebga_cfg_t                cfg,
  input  wire ebga_cmd_t                cmd,
  output ebga_status_t                  status,
  input  wire logic [NOW_W-1:0]         now_ms,
  input  wire logic [GAP_W-1:0]         blink_gap,
  input  wire logic signed [GAZE_W-1:0] target_x,
  input  wire logic signed [GAZE_W-1:0] target_y,
  input  wire logic [GAP_W-1:0]         saccade_gap,
  output logic [LEVEL_W-1:0]            eye_open,
  output logic [HEIGHT_W-1:0]           eye_height,
  output logic [RADIUS_W-1:0]           corner_radius,
  output logic signed [GAZE_W-1:0]      gaze_x,
  output logic signed [GAZE_W-1:0]      gaze_y
);

  // Moves one gaze axis from its start toward its target by the eased fraction.
  function automatic logic [GAZE_W-1:0] ease_axis(logic [GAZE_W-1:0] from,
                                                  logic [GAZE_W-1:0] to,
                                                  logic [16:0]       s);
    logic signed [GAZE_W:0] from6;
    logic signed [GAZE_W:0] diff;
    logic signed [GAZE_W:0] mag6;
    logic [21:0]            prod;
    logic signed [GAZE_W:0] step;
    logic signed [GAZE_W:0] pos;
    from6 = $signed({from[GAZE_W-1], from});
    diff  = $signed({to[GAZE_W-1], to}) - from6;
    mag6  = diff[GAZE_W] ? -diff : diff;
    prod  = 22'(mag6[GAZE_W-1:0]) * 22'(s);
    step  = $signed({1'b0, prod[20:16]});
    pos   = diff[GAZE_W] ? from6 - step : from6 + step;
    return pos[GAZE_W-1:0];
  endfunction

  // Latched frame fields.
  logic [TIME_WIDTH-1:0]    now_r;
  logic [GAP_W-1:0]         bgap_r;
  logic [GAP_W-1:0]         sgap_r;
  logic [GAZE_W-1:0]        tx_r;
  logic [GAZE_W-1:0]        ty_r;

  // Animation state.
  logic [TIME_WIDTH-1:0]    blink_due;
  logic [TIME_WIDTH-1:0]    blink_end_time;
  logic [TIME_WIDTH-1:0]    saccade_start;
  logic [TIME_WIDTH-1:0]    saccade_due;
  logic [GAZE_W-1:0]        gaze_now_x;
  logic [GAZE_W-1:0]        gaze_now_y;
  logic [GAZE_W-1:0]        gaze_from_x;
  logic [GAZE_W-1:0]        gaze_from_y;
  logic [GAZE_W-1:0]        gaze_to_x;
  logic [GAZE_W-1:0]        gaze_to_y;

  // Intermediate results.
  logic                     blink_act_r;
  logic                     tri_full_r;
  logic                     p_full_r;
  logic [LEVEL_W-1:0]       open_r;
  logic [HEIGHT_W-1:0]      height_r;
  logic [16:0]              p_r;
  logic [32:0]              p2_r;
  logic [16:0]              s_r;

  // Divider hookup.
  logic                     div_start;
  logic [DUR_W-1:0]         div_rem_init;
  logic [DUR_W-1:0]         div_divisor;
  logic [DIV_STEPS_W-1:0]   div_steps;
  logic                     div_busy;
  logic [DUR_W-1:0]         div_quot;

  // Combinational terms.
  logic [TIME_WIDTH-1:0]    blink_end_new;
  logic [TIME_WIDTH-1:0]    r_full;
  logic [DUR_W-1:0]         r_sat;
  logic [DUR_W:0]           two_r;
  logic [DUR_W:0]           dur17;
  logic [DUR_W:0]           dd17;
  logic [DUR_W-1:0]         dd;
  logic                     blink_act;
  logic [TIME_WIDTH-1:0]    t_elapsed;
  logic [LEVEL_W-1:0]       closed_sat;
  logic [LEVEL_W-1:0]       span;
  logic [LEVEL_W-1:0]       tri_q8;
  logic [17:0]              open_prod;
  logic [LEVEL_W-1:0]       open_calc;
  logic [18:0]              h_prod;
  logic [10:0]              h_raw;
  logic [HEIGHT_W-1:0]      height_calc;
  logic [HEIGHT_W-1:0]      min_wh;
  logic [RADIUS_W-1:0]      half_wh;
  logic [RADIUS_W-1:0]      radius_calc;
  logic [16:0]              p_sel;
  logic [33:0]              p_sq;
  logic [17:0]              smooth_w;
  logic [50:0]              smooth_prod;

  // Triangle distance from the middle of the blink.
  always_comb begin
    blink_end_new = now_r + TIME_WIDTH'(cfg.blink_duration);
    blink_act     = (now_r < blink_end_time) && (cfg.blink_duration != '0);
    r_full        = blink_end_time - now_r;
    r_sat         = (r_full > TIME_WIDTH'(cfg.blink_duration)) ? cfg.blink_duration
                                                                : r_full[DUR_W-1:0];
    two_r         = {r_sat, 1'b0};
    dur17         = {1'b0, cfg.blink_duration};
    dd17          = (two_r >= dur17) ? two_r - dur17 : dur17 - two_r;
    dd            = dd17[DUR_W-1:0];
    t_elapsed     = now_r - saccade_start;
  end

  // The divider serves the blink fraction first, then the saccade progress.
  always_comb begin
    div_start    = cmd.bdiv_start || cmd.pdiv_start;
    div_rem_init = cmd.bdiv_start ? dd : t_elapsed[DUR_W-1:0];
    div_divisor  = cmd.bdiv_start ? cfg.blink_duration : cfg.saccade_duration;
    div_steps    = cmd.bdiv_start ? TRI_STEPS : PROGRESS_STEPS;
  end

  ebga_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  assign status.div_busy = div_busy;

  // Openness, height and corner radius.
  always_comb begin
    closed_sat  = (cfg.closed_level > Q8_ONE) ? Q8_ONE : cfg.closed_level;
    span        = Q8_ONE - closed_sat;
    tri_q8      = tri_full_r ? Q8_ONE : {1'b0, div_quot[7:0]};
    open_prod   = 18'(span) * 18'(tri_q8);
    open_calc   = closed_sat + open_prod[16:8];
    h_prod      = 19'(cfg.eye_full_height) * 19'(open_r);
    h_raw       = h_prod[18:8];
    if (h_raw < 11'(MIN_HEIGHT)) begin
      height_calc = MIN_HEIGHT;
    end else if (h_raw[10]) begin
      height_calc = '1;
    end else begin
      height_calc = h_raw[HEIGHT_W-1:0];
    end
    min_wh      = (cfg.eye_width < height_r) ? cfg.eye_width : height_r;
    half_wh     = min_wh[HEIGHT_W-1:1];
    radius_calc = (half_wh > cfg.corner_limit) ? cfg.corner_limit : half_wh;
  end

  // Saccade progress and Q16 smoothstep.
  always_comb begin
    p_sel       = p_full_r ? Q16_ONE : {1'b0, div_quot};
    p_sq        = 34'(p_sel) * 34'(p_sel);
    smooth_w    = SMOOTH_THREE - {p_r, 1'b0};
    smooth_prod = 51'(p2_r) * 51'(smooth_w);
  end

  // Animation state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_due      <= '0;
      blink_end_time <= '0;
      saccade_start  <= '0;
      saccade_due    <= '0;
      gaze_now_x     <= '0;
      gaze_now_y     <= '0;
      gaze_from_x    <= '0;
      gaze_from_y    <= '0;
      gaze_to_x      <= '0;
      gaze_to_y      <= '0;
    end else begin
      if (cmd.trigger && (now_r >= blink_due)) begin
        blink_end_time <= blink_end_new;
        blink_due      <= blink_end_new + TIME_WIDTH'(bgap_r);
      end
      if (cmd.trigger && (now_r >= saccade_due)) begin
        gaze_from_x   <= gaze_now_x;
        gaze_from_y   <= gaze_now_y;
        gaze_to_x     <= tx_r;
        gaze_to_y     <= ty_r;
        saccade_start <= now_r;
        saccade_due   <= now_r + TIME_WIDTH'(cfg.saccade_duration) + TIME_WIDTH'(sgap_r);
      end
      if (cmd.gaze_en) begin
        gaze_now_x <= ease_axis(gaze_from_x, gaze_to_x, s_r);
        gaze_now_y <= ease_axis(gaze_from_y, gaze_to_y, s_r);
      end
    end
  end

  // Frame capture and intermediate results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= TIME_WIDTH'(now_ms);
      bgap_r <= blink_gap;
      sgap_r <= saccade_gap;
      tx_r   <= target_x;
      ty_r   <= target_y;
    end
    if (cmd.bdiv_start) begin
      blink_act_r <= blink_act;
      tri_full_r  <= dd == cfg.blink_duration;
    end
    if (cmd.open_en) begin
      open_r <= blink_act_r ? open_calc : Q8_ONE;
    end
    if (cmd.height_en) begin
      height_r <= height_calc;
    end
    if (cmd.pdiv_start) begin
      p_full_r <= t_elapsed >= TIME_WIDTH'(cfg.saccade_duration);
    end
    if (cmd.p2_en) begin
      p_r  <= p_sel;
      p2_r <= p_sq[32:0];
    end
    if (cmd.smooth_en) begin
      s_r <= smooth_prod[48:32];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      eye_open      <= open_r;
      eye_height    <= height_r;
      corner_radius <= radius_calc;
      gaze_x        <= gaze_now_x;
      gaze_y        <= gaze_now_y;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ebga_ctrl.sv
// Controller: sequences one frame tick through the datapath and owns the handshakes.
`default_nettype none

module ebga_ctrl import ebga_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire ebga_status_t status,
  output ebga_cmd_t         cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_TRIG   = 12'b0000_0000_0010,
    S_BDIV   = 12'b0000_0000_0100,
    S_BWAIT  = 12'b0000_0000_1000,
    S_OPEN   = 12'b0000_0001_0000,
    S_HEIGHT = 12'b0000_0010_0000,
    S_PDIV   = 12'b0000_0100_0000,
    S_PWAIT  = 12'b0000_1000_0000,
    S_P2     = 12'b0001_0000_0000,
    S_SMOOTH = 12'b0010_0000_0000,
    S_GAZE   = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_TRIG;
      S_TRIG:   state_next = S_BDIV;
      S_BDIV:   state_next = S_BWAIT;
      S_BWAIT:  if (!status.div_busy) state_next = S_OPEN;
      S_OPEN:   state_next = S_HEIGHT;
      S_HEIGHT: state_next = S_PDIV;
      S_PDIV:   state_next = S_PWAIT;
      S_PWAIT:  if (!status.div_busy) state_next = S_P2;
      S_P2:     state_next = S_SMOOTH;
      S_SMOOTH: state_next = S_GAZE;
      S_GAZE:   state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd            = '0;
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.trigger    = state == S_TRIG;
    cmd.bdiv_start = state == S_BDIV;
    cmd.open_en    = (state == S_BWAIT) && !status.div_busy;
    cmd.height_en  = state == S_HEIGHT;
    cmd.pdiv_start = state == S_PDIV;
    cmd.p2_en      = (state == S_PWAIT) && !status.div_busy;
    cmd.smooth_en  = state == S_SMOOTH;
    cmd.gaze_en    = state == S_GAZE;
    cmd.out_load   = (state == S_OUT) && out_free;
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/eye_blink_gaze_animator_top.sv
// Top level of the eye blink and gaze animator: register port, controller and datapath.
//
// Each frame tick transfer carries the time in milliseconds and four random draws; the
// block answers with one result transfer holding eye openness (Q8), eye height, corner
// radius and the gaze offset. A new tick is taken only after the last one is done.
// The shared one-bit-per-cycle divider takes 8 steps for the blink fraction and 16 for
// the saccade progress; a result waiting at the output holds the block only if it is
// still not taken when the next one is finished. Registers sit at byte addresses 4*i;
// the user must write them only while the block is idle; the block does not enforce it.
`default_nettype none

module eye_blink_gaze_animator_top import ebga_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  ebga_frame_if.sink                 frame,
  ebga_result_if.source              result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  ebga_cfg_t    cfg;
  ebga_cmd_t    cmd;
  ebga_status_t status;
  ebga_reg_t    reg_sel;
  logic         cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = ebga_reg_t'(paddr[APB_ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_duration   <= BLINK_DURATION_RST;
      cfg.closed_level     <= CLOSED_LEVEL_RST;
      cfg.saccade_duration <= SACCADE_DURATION_RST;
      cfg.eye_full_height  <= EYE_FULL_HEIGHT_RST;
      cfg.eye_width        <= EYE_WIDTH_RST;
      cfg.corner_limit     <= CORNER_LIMIT_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_BLINK_DURATION:   cfg.blink_duration   <= pwdata[DUR_W-1:0];
        REG_CLOSED_LEVEL:     cfg.closed_level     <= pwdata[LEVEL_W-1:0];
        REG_SACCADE_DURATION: cfg.saccade_duration <= pwdata[DUR_W-1:0];
        REG_EYE_FULL_HEIGHT:  cfg.eye_full_height  <= pwdata[HEIGHT_W-1:0];
        REG_EYE_WIDTH:        cfg.eye_width        <= pwdata[HEIGHT_W-1:0];
        REG_CORNER_LIMIT:     cfg.corner_limit     <= pwdata[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_BLINK_DURATION:   prdata = APB_DATA_W'(cfg.blink_duration);
      REG_CLOSED_LEVEL:     prdata = APB_DATA_W'(cfg.closed_level);
      REG_SACCADE_DURATION: prdata = APB_DATA_W'(cfg.saccade_duration);
      REG_EYE_FULL_HEIGHT:  prdata = APB_DATA_W'(cfg.eye_full_height);
      REG_EYE_WIDTH:        prdata = APB_DATA_W'(cfg.eye_width);
      REG_CORNER_LIMIT:     prdata = APB_DATA_W'(cfg.corner_limit);
      default:              prdata = '0;
    endcase
  end

  ebga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ebga_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .now_ms        (frame.now_ms),
    .blink_gap     (frame.blink_gap),
    .target_x      (frame.target_x),
    .target_y      (frame.target_y),
    .saccade_gap   (frame.saccade_gap),
    .eye_open      (result.eye_open),
    .eye_height    (result.eye_height),
    .corner_radius (result.corner_radius),
    .gaze_x        (result.gaze_x),
    .gaze_y        (result.gaze_y)
  );

endmodule

`default_nettype wire
